### rtl/tdp_pkg.sv
// Shared types and constants for the trial-division prime tester.
// No dependencies; imported by tdp_serial_rem and trial_division_prime_test_unit.
package tdp_pkg;

  localparam int unsigned NUM_WIDTH = 32;
  // Trial divisor never passes sqrt(2^NUM_WIDTH) + 1.
  localparam int unsigned DIV_WIDTH = NUM_WIDTH / 2 + 1;
  // Running divisor square, one bit of headroom over the candidate.
  localparam int unsigned SQ_WIDTH  = NUM_WIDTH + 1;
  localparam int unsigned CNT_WIDTH = $clog2(NUM_WIDTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV
  } tdp_state_e;

  typedef struct packed {
    logic done;
    logic zero;
  } tdp_rem_status_t;

endpackage

### rtl/tdp_serial_rem.sv
// Bit-serial restoring remainder: one dividend bit per cycle, MSB first.
// Depends on tdp_pkg.
module tdp_serial_rem import tdp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  logic [NUM_WIDTH-1:0] dividend_i,
  input  logic [DIV_WIDTH-1:0] divisor_i,
  output tdp_rem_status_t      status_o
);

  logic [NUM_WIDTH-1:0] shift_q, shift_d;
  logic [DIV_WIDTH-1:0] rem_q, rem_d;
  logic [CNT_WIDTH-1:0] cnt_q, cnt_d;
  logic                 active_q, active_d;
  tdp_rem_status_t      status_q, status_d;

  logic [DIV_WIDTH:0]   trial;
  logic [DIV_WIDTH-1:0] rem_next;

  always_comb begin
    trial = {rem_q, shift_q[NUM_WIDTH-1]};
    if (trial >= {1'b0, divisor_i}) begin
      rem_next = DIV_WIDTH'(trial - {1'b0, divisor_i});
    end else begin
      rem_next = trial[DIV_WIDTH-1:0];
    end

    shift_d  = shift_q;
    rem_d    = rem_q;
    cnt_d    = cnt_q;
    active_d = active_q;
    status_d = '0;

    if (load_i) begin
      shift_d  = dividend_i;
      rem_d    = '0;
      cnt_d    = CNT_WIDTH'(NUM_WIDTH - 1);
      active_d = 1'b1;
    end else if (active_q) begin
      shift_d = {shift_q[NUM_WIDTH-2:0], 1'b0};
      rem_d   = rem_next;
      cnt_d   = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        active_d      = 1'b0;
        status_d.done = 1'b1;
        status_d.zero = (rem_next == '0);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q    <= '0;
      status_q <= '0;
    end else begin
      active_q <= active_d;
      cnt_q    <= cnt_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    rem_q   <= rem_d;
  end

  assign status_o = status_q;

endmodule

### rtl/trial_division_prime_test_unit.sv
// Top level of the trial-division prime tester: control FSM, divisor and square.
// Depends on tdp_pkg and tdp_serial_rem.
//
//  channel  | strobe / accept          | payload
//  ---------+--------------------------+-------------------------
//  command  | start & !busy            | candidate_i [31:0]
//  result   | done_o, one cycle        | is_prime_o
//
// Candidates 0 and 1 answer in the cycle after start, without going busy.
// Otherwise each trial divisor takes a bound check in ST_CHECK, then a pass
// through the bit-serial remainder unit in ST_DIV.
// Reset is asynchronous and leaves the unit idle. done_o cannot be stalled.
module trial_division_prime_test_unit import tdp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [NUM_WIDTH-1:0] candidate_i,
  output logic                 done_o,
  output logic                 is_prime_o
);

  tdp_state_e           state_q, state_d;
  logic [NUM_WIDTH-1:0] cand_q, cand_d;
  logic [DIV_WIDTH-1:0] div_q, div_d;
  logic [SQ_WIDTH-1:0]  sq_q, sq_d;
  logic                 valid_q, valid_d;
  logic                 prime_q, prime_d;
  logic                 rem_load;
  tdp_rem_status_t      rem_status;

  tdp_serial_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (rem_load),
    .dividend_i (cand_q),
    .divisor_i  (div_q),
    .status_o   (rem_status)
  );

  always_comb begin
    state_d  = state_q;
    cand_d   = cand_q;
    div_d    = div_q;
    sq_d     = sq_q;
    valid_d  = 1'b0;
    prime_d  = prime_q;
    rem_load = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cand_d = candidate_i;
          div_d  = DIV_WIDTH'(2);
          sq_d   = SQ_WIDTH'(4);
          if (candidate_i[NUM_WIDTH-1:1] == '0) begin
            valid_d = 1'b1;
            prime_d = 1'b0;
          end else begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (sq_q > {1'b0, cand_q}) begin
          valid_d = 1'b1;
          prime_d = 1'b1;
          state_d = ST_IDLE;
        end else begin
          rem_load = 1'b1;
          state_d  = ST_DIV;
        end
      end
      ST_DIV: begin
        if (rem_status.done) begin
          if (rem_status.zero) begin
            valid_d = 1'b1;
            prime_d = 1'b0;
            state_d = ST_IDLE;
          end else begin
            // (d+1)^2 = d^2 + 2d + 1
            div_d   = div_q + 1'b1;
            sq_d    = sq_q + SQ_WIDTH'({div_q, 1'b1});
            state_d = ST_CHECK;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
      div_q   <= DIV_WIDTH'(2);
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      div_q   <= div_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q  <= cand_d;
    sq_q    <= sq_d;
    prime_q <= prime_d;
  end

  assign busy       = (state_q != ST_IDLE);
  assign done_o     = valid_q;
  assign is_prime_o = prime_q;

  a_small_not_prime: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && candidate_i[NUM_WIDTH-1:1] == '0) |=> (done_o && !is_prime_o))
    else $error("candidate 0 or 1 not answered as composite");

  a_start_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted beat neither running nor answered");

  a_prime_from_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && is_prime_o) |-> ($past(state_q) == ST_CHECK))
    else $error("prime reported outside the bound check");

  a_divisor_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (div_q >= DIV_WIDTH'(2)))
    else $error("trial divisor below two");

endmodule
